// ----- design/bpsel_pkg.sv -----
// Shared constants, codes, state type and cell control structures for the profile selector.
package bpsel_pkg;

   localparam int MAX_PROFILES_DEF = 16;
   localparam int BW_BITS_DEF      = 32;

   localparam int CMD_W     = 2;
   localparam int IN_IDX_W  = 8;
   localparam int OUT_IDX_W = 4;
   localparam int STATUS_W  = 2;
   localparam int CFG_W     = 8;

   localparam logic [CFG_W-1:0] CONSISTENCY_RESET = 8'd2;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DECIDE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_RESOLVE
   } bpsel_state_type;

   typedef struct packed {
      logic compare;
      logic insert;
      logic overwrite;
   } cell_ctrl_type;

   typedef struct packed {
      logic valid;
      logic le;
      logic eq;
   } cell_link_type;

endpackage

// ----- design/bpsel_if.sv -----
// Handshake interfaces for the request, response and configuration channels.
interface bpsel_req_if
   import bpsel_pkg::*;
#(
   parameter int BW_BITS = BW_BITS_DEF
);
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [BW_BITS-1:0]  profile_bandwidth;
   logic                profile_is_iframe;
   logic [IN_IDX_W-1:0] current_index;
   logic [BW_BITS-1:0]  current_bandwidth;
   logic [BW_BITS-1:0]  network_bandwidth;
   logic                network_known;

   modport source (
      output valid, cmd, profile_bandwidth, profile_is_iframe, current_index,
             current_bandwidth, network_bandwidth, network_known,
      input  ready
   );
   modport sink (
      input  valid, cmd, profile_bandwidth, profile_is_iframe, current_index,
             current_bandwidth, network_bandwidth, network_known,
      output ready
   );
endinterface

interface bpsel_rsp_if
   import bpsel_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [OUT_IDX_W-1:0] desired_index;
   logic                 index_changed;
   logic [STATUS_W-1:0]  status;

   modport source (output valid, desired_index, index_changed, status, input ready);
   modport sink (input valid, desired_index, index_changed, status, output ready);
endinterface

interface bpsel_csr_if
   import bpsel_pkg::*;
;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] consistency_count;

   modport source (output valid, consistency_count, input ready);
   modport sink (input valid, consistency_count, output ready);
endinterface

// ----- design/bpsel_cell.sv -----
// One table cell: holds one sorted entry, compares it against the keys and shifts on insert.
module bpsel_cell
   import bpsel_pkg::*;
#(
   parameter int POS          = 0,
   parameter int MAX_PROFILES = MAX_PROFILES_DEF,
   parameter int BW_BITS      = BW_BITS_DEF
)(
   input  logic                              clock,
   input  logic                              reset,
   input  cell_ctrl_type                     ctrl,
   input  logic [$clog2(MAX_PROFILES+1)-1:0] count,
   input  logic [BW_BITS-1:0]                match_key,
   input  logic [BW_BITS-1:0]                limit_key,
   input  logic [$clog2(MAX_PROFILES)-1:0]   new_idx,
   input  logic [BW_BITS-1:0]                prev_bw,
   input  logic [$clog2(MAX_PROFILES)-1:0]   prev_idx,
   input  cell_link_type                     prev_link,
   input  cell_link_type                     next_link,
   output logic [BW_BITS-1:0]                bw,
   output logic [$clog2(MAX_PROFILES)-1:0]   idx,
   output cell_link_type                     link,
   output logic [$clog2(MAX_PROFILES)-1:0]   sel_idx,
   output logic                              up_step,
   output logic                              down_step
);
   localparam int IW = $clog2(MAX_PROFILES);
   localparam int CW = $clog2(MAX_PROFILES + 1);

   logic [BW_BITS-1:0] bw_ff, bw_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic               eq_ff, eq_in;
   logic               le_ff, le_in;
   logic               valid;
   logic               sel;

   assign valid = CW'(POS) < count;

   always_comb begin
      eq_in = eq_ff;
      le_in = le_ff;
      if (ctrl.compare) begin
         eq_in = valid && (bw_ff == match_key);
         le_in = valid && (bw_ff <= limit_key);
      end
   end

   always_comb begin
      bw_in  = bw_ff;
      idx_in = idx_ff;
      if (ctrl.insert && !le_ff) begin
         if (prev_link.le) begin
            bw_in  = match_key;
            idx_in = new_idx;
         end else if (prev_link.valid) begin
            bw_in  = prev_bw;
            idx_in = prev_idx;
         end
      end
      if (ctrl.overwrite && eq_ff) begin
         idx_in = new_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eq_ff <= 1'b0;
         le_ff <= 1'b0;
      end else begin
         eq_ff <= eq_in;
         le_ff <= le_in;
      end
   end

   always_ff @(posedge clock) begin
      bw_ff  <= bw_in;
      idx_ff <= idx_in;
   end

   assign sel       = le_ff && !next_link.le;
   assign bw        = bw_ff;
   assign idx       = idx_ff;
   assign link      = '{valid: valid, le: le_ff, eq: eq_ff};
   assign sel_idx   = sel ? idx_ff : '0;
   assign up_step   = sel && prev_link.eq;
   assign down_step = sel && next_link.eq;

endmodule

// ----- design/bitrate_profile_selector_unit.sv -----
// Top level of the bitrate profile selector: control sequencer, cell row and result register.
// A request is transferred in idle; in the compare state every cell of the row compares its
// entry with the keys at once, and in the resolve state the cells shift, insert or overwrite
// and the result register is loaded. A new request is taken only in idle, so not before the
// last one is through, and a waiting response holds the unit in resolve and so blocks the
// next request. The table holds MAX_PROFILES entries in a row of cells sorted by bandwidth.
// The consistency count may be written at any time the unit is idle.
module bitrate_profile_selector_unit
   import bpsel_pkg::*;
#(
   parameter int MAX_PROFILES = MAX_PROFILES_DEF,
   parameter int BW_BITS      = BW_BITS_DEF
)(
   input  logic         clock,
   input  logic         reset,
   bpsel_req_if.sink    req_chan,
   bpsel_rsp_if.source  rsp_chan,
   bpsel_csr_if.sink    csr_chan
);
   localparam int IW = $clog2(MAX_PROFILES);
   localparam int CW = $clog2(MAX_PROFILES + 1);

   bpsel_state_type state_ff, state_in;

   logic [CMD_W-1:0]    cmd_ff;
   logic [BW_BITS-1:0]  pbw_ff, cbw_ff, nbw_ff;
   logic                iframe_ff, known_ff;
   logic [IN_IDX_W-1:0] cur_ff;

   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    total_ff, total_in;
   logic [CFG_W-1:0] up_ff, up_in;
   logic [CFG_W-1:0] down_ff, down_in;
   logic [CFG_W-1:0] cc_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_W-1:0] desired_ff, desired_in;
   logic                 changed_ff, changed_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   logic          accept;
   logic          go;
   cell_ctrl_type ctrl;
   logic [BW_BITS-1:0] match_key, limit_key;

   logic [BW_BITS-1:0] cell_bw   [MAX_PROFILES];
   logic [IW-1:0]      cell_idx  [MAX_PROFILES];
   logic [IW-1:0]      cell_sel  [MAX_PROFILES];
   cell_link_type      cell_link [MAX_PROFILES];
   logic               cell_up   [MAX_PROFILES];
   logic               cell_down [MAX_PROFILES];

   logic          any_eq, any_le, up_step, down_step;
   logic [IW-1:0] sel_idx;
   logic [IW-1:0] cur_cl, desired;
   logic          full, add_ok;
   logic [CFG_W-1:0] up_inc, down_inc;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign go             = (state_ff == ST_RESOLVE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (accept) state_in = ST_COMPARE;
         ST_COMPARE: state_in = ST_RESOLVE;
         ST_RESOLVE: if (go) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_chan.cmd;
         pbw_ff    <= req_chan.profile_bandwidth;
         iframe_ff <= req_chan.profile_is_iframe;
         cur_ff    <= req_chan.current_index;
         cbw_ff    <= req_chan.current_bandwidth;
         nbw_ff    <= req_chan.network_bandwidth;
         known_ff  <= req_chan.network_known;
      end
   end

   assign match_key = (cmd_ff == CMD_ADD) ? pbw_ff : cbw_ff;
   assign limit_key = (cmd_ff == CMD_ADD) ? pbw_ff : nbw_ff;

   assign full   = total_ff >= CW'(MAX_PROFILES);
   assign add_ok = (cmd_ff == CMD_ADD) && !full && !iframe_ff;

   always_comb begin
      ctrl.compare   = (state_ff == ST_COMPARE);
      ctrl.insert    = go && add_ok && !any_eq;
      ctrl.overwrite = go && add_ok && any_eq;
   end

   for (genvar i = 0; i < MAX_PROFILES; i++) begin : g_cell
      logic [BW_BITS-1:0] prev_bw;
      logic [IW-1:0]      prev_idx;
      cell_link_type      prev_link;
      cell_link_type      next_link;

      if (i == 0) begin : g_first
         assign prev_bw   = '0;
         assign prev_idx  = '0;
         assign prev_link = '{valid: 1'b0, le: 1'b1, eq: 1'b0};
      end else begin : g_inner
         assign prev_bw   = cell_bw[i-1];
         assign prev_idx  = cell_idx[i-1];
         assign prev_link = cell_link[i-1];
      end

      if (i == MAX_PROFILES - 1) begin : g_last
         assign next_link = '{valid: 1'b0, le: 1'b0, eq: 1'b0};
      end else begin : g_mid
         assign next_link = cell_link[i+1];
      end

      bpsel_cell #(
         .POS          (i),
         .MAX_PROFILES (MAX_PROFILES),
         .BW_BITS      (BW_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .count     (count_ff),
         .match_key (match_key),
         .limit_key (limit_key),
         .new_idx   (total_ff[IW-1:0]),
         .prev_bw   (prev_bw),
         .prev_idx  (prev_idx),
         .prev_link (prev_link),
         .next_link (next_link),
         .bw        (cell_bw[i]),
         .idx       (cell_idx[i]),
         .link      (cell_link[i]),
         .sel_idx   (cell_sel[i]),
         .up_step   (cell_up[i]),
         .down_step (cell_down[i])
      );
   end

   always_comb begin
      any_eq    = 1'b0;
      up_step   = 1'b0;
      down_step = 1'b0;
      sel_idx   = '0;
      for (int i = 0; i < MAX_PROFILES; i++) begin
         any_eq    = any_eq | cell_link[i].eq;
         up_step   = up_step | cell_up[i];
         down_step = down_step | cell_down[i];
         sel_idx   = sel_idx | cell_sel[i];
      end
   end

   assign any_le = cell_link[0].le;

   always_comb begin
      if (total_ff == '0) begin
         cur_cl = '0;
      end else if (32'(cur_ff) >= 32'(total_ff)) begin
         cur_cl = IW'(total_ff - 1'b1);
      end else begin
         cur_cl = IW'(cur_ff);
      end
   end

   assign up_inc   = up_ff + 1'b1;
   assign down_inc = down_ff + 1'b1;

   always_comb begin
      count_in   = count_ff;
      total_in   = total_ff;
      up_in      = up_ff;
      down_in    = down_ff;
      desired    = cur_cl;
      desired_in = '0;
      changed_in = 1'b0;
      status_in  = STATUS_OK;
      unique case (cmd_ff)
         CMD_CLEAR: begin
            count_in = '0;
            total_in = '0;
         end
         CMD_ADD: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               total_in = total_ff + 1'b1;
               if (!iframe_ff && !any_eq) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         CMD_DECIDE: begin
            if (count_ff == '0 || !known_ff) begin
               up_in   = '0;
               down_in = '0;
               if (count_ff == '0) begin
                  status_in = STATUS_EMPTY;
               end
            end else if (nbw_ff > cbw_ff) begin
               down_in = '0;
               up_in   = '0;
               if (any_eq) begin
                  desired = sel_idx;
                  if (up_step) begin
                     if (up_inc < cc_ff) begin
                        desired = cur_cl;
                        up_in   = up_inc;
                     end
                  end
               end
            end else begin
               up_in   = '0;
               down_in = '0;
               desired = any_le ? sel_idx : cell_idx[0];
               if (any_le && down_step) begin
                  if (down_inc < cc_ff) begin
                     desired = cur_cl;
                     down_in = down_inc;
                  end
               end
            end
            desired_in = OUT_IDX_W'(desired);
            changed_in = desired != cur_cl;
         end
         CMD_NOP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
         up_ff    <= '0;
         down_ff  <= '0;
      end else if (go) begin
         count_ff <= count_in;
         total_ff <= total_in;
         up_ff    <= up_in;
         down_ff  <= down_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff <= CONSISTENCY_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         cc_ff <= csr_chan.consistency_count;
      end
   end

   assign rsp_valid_in = go || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         desired_ff <= desired_in;
         changed_ff <= changed_in;
         status_ff  <= status_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.desired_index = desired_ff;
   assign rsp_chan.index_changed = changed_ff;
   assign rsp_chan.status        = status_ff;

   // The table never holds more entries than profiles that were added.
   a_count_le_total: assert property (@(posedge clock) disable iff (reset)
      count_ff <= total_ff)
      else $error("table count exceeds profile total");

   // A new response is loaded only at the end of a resolve cycle.
   a_rsp_from_resolve: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESOLVE))
      else $error("response raised outside resolve");

   // A request transfer always leads into the compare cycle.
   a_accept_to_compare: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_COMPARE)
      else $error("request transfer not followed by compare");

   // A one-step move is only flagged next to the entry that matches the current bandwidth.
   a_step_needs_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESOLVE) && (up_step || down_step) |-> any_eq)
      else $error("inconsistent match flags");

endmodule
